[hw/rtl/plc_pkg.sv]
// Shared types and constants for the positional list store.
package plc_pkg;

  // Fixed field widths of the command beat
  localparam int unsigned CmdW = 2;
  localparam int unsigned PosW = 7;

  // Command codes; the fourth code is unused and is ignored
  typedef enum logic [CmdW-1:0] {
    CmdInsert   = 2'd0,
    CmdRemove   = 2'd1,
    CmdRetrieve = 2'd2
  } plc_cmd_e;

  // Broadcast to every cell for one accepted beat
  typedef struct packed {
    logic ins;  // open a slot at the target and load the new value
    logic rem;  // close the slot at the target
  } plc_op_t;

endpackage

[hw/rtl/plc_cell.sv]
// One list slot: holds an entry, shifts with its neighbours, drives read data.
module plc_cell import plc_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  plc_op_t               op_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  hit, above;

  assign hit   = (idx_i == MyIdx);
  assign above = (MyIdx > idx_i);

  // Pick the next entry: take from below on insert, from above on remove
  always_comb begin
    data_d = data_q;
    if (op_i.ins) begin
      if (hit) begin
        data_d = value_i;
      end else if (above) begin
        data_d = left_i;
      end
    end else if (op_i.rem && (hit || above)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Drive the entry onto the read bus only when addressed
  assign rd_o   = hit ? data_q : '0;

endmodule

[hw/rtl/positional_list_store_unit.sv]
// Top level of the positional list store: command decode, cell row, result register.
//
//  channel | valid / ready          | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid_i / in_ready_o| command_i, position_i, item_value_i
//  out     | out_valid_o/out_ready_i| ok_o, read_value_o, length_o, is_empty_o
//
//  One command per cycle unless the output stalls: every cell shifts or loads in the
//  accepting cycle, and the result appears in the output register on the next cycle.
//  A new beat is taken whenever the output register is empty or being drained.
//  Reset clears the entry count and the output valid; entries are not cleared.
//  A stalled result holds, and no command is taken until it is drained.
module positional_list_store_unit import plc_pkg::*; #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CntW      = $clog2(CAPACITY + 1),
  localparam int unsigned IdxW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CmdW-1:0]       command_i,
  input  logic [PosW-1:0]       position_i,
  input  logic [DATA_WIDTH-1:0] item_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  ok_o,
  output logic [DATA_WIDTH-1:0] read_value_o,
  output logic [CntW-1:0]       length_o,
  output logic                  is_empty_o
);

  // Common compare width, one bit extra so that count + 1 never wraps
  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam logic [CmpW-1:0] Cap = CmpW'(CAPACITY);

  logic [CntW-1:0]       count_q, count_d;
  logic                  out_valid_q;
  logic                  ok_q;
  logic [DATA_WIDTH-1:0] rd_q;

  logic                  accept;
  logic [CmpW-1:0]       pos_ext, cnt_ext, idx_ext;
  logic                  pos_nz, in_list, ins_ok, rem_ok, get_ok, cmd_ok;
  plc_op_t               op;
  logic [IdxW-1:0]       idx;
  logic [DATA_WIDTH-1:0] rd_bus;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Range checks against the current length
  assign pos_ext = CmpW'(position_i);
  assign cnt_ext = CmpW'(count_q);
  assign pos_nz  = (position_i != '0);
  assign in_list = pos_nz && (pos_ext <= cnt_ext);
  assign idx_ext = pos_ext - CmpW'(1);
  assign idx     = idx_ext[IdxW-1:0];

  always_comb begin
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    get_ok = 1'b0;
    unique case (command_i)
      CmdInsert:   ins_ok = pos_nz && (pos_ext <= cnt_ext + CmpW'(1)) && (cnt_ext < Cap);
      CmdRemove:   rem_ok = in_list;
      CmdRetrieve: get_ok = in_list;
      default:     ;
    endcase
  end

  assign cmd_ok = ins_ok || rem_ok || get_ok;
  assign op.ins = accept && ins_ok;
  assign op.rem = accept && rem_ok;

  // Row of cells, each handing its entry to both neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    plc_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IdxW),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .idx_i   (idx),
      .value_i (item_value_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // Merge the one addressed cell onto the read bus
  always_comb begin
    rd_bus = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // Advance the length
  always_comb begin
    count_d = count_q;
    if (op.ins) begin
      count_d = count_q + CntW'(1);
    end else if (op.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q <= cmd_ok;
      rd_q <= (accept && get_ok) ? rd_bus : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign read_value_o = rd_q;
  assign length_o     = count_q;
  assign is_empty_o   = (count_q == '0);

endmodule

[hw/rtl/plc_checker.sv]
// Port-level checks for the positional list store, bound to the top level.
module plc_checker import plc_pkg::*; #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CntW      = $clog2(CAPACITY + 1)
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  ok_o,
  input logic [DATA_WIDTH-1:0] read_value_o,
  input logic [CntW-1:0]       length_o,
  input logic                  is_empty_o
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ok_o) &&
      $stable(read_value_o) && $stable(length_o))
    else $error("result beat changed while stalled");

  // Empty flag agrees with the length
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (length_o == '0)))
    else $error("empty flag disagrees with length");

  // Length never exceeds the capacity
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (length_o <= CntW'(CAPACITY)))
    else $error("length beyond capacity");

  // A failed command reads zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> (read_value_o == '0))
    else $error("failed command returned data");

  // An accepted command yields a result on the next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted command gave no result");

endmodule

bind positional_list_store_unit plc_checker #(
  .CAPACITY   (CAPACITY),
  .DATA_WIDTH (DATA_WIDTH)
) u_plc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .ok_o         (ok_o),
  .read_value_o (read_value_o),
  .length_o     (length_o),
  .is_empty_o   (is_empty_o)
);

[verif/tb_top.sv]
// Self-checking testbench for the positional list store unit.
`timescale 1ns / 100ps

module tb_top;
  import plc_pkg::*;

  localparam int unsigned ListDepth = 64;
  localparam int unsigned ValW      = 32;
  localparam int unsigned LenW      = $clog2(ListDepth + 1);
  // The fourth command code has no enum member; the block ignores it
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  typedef struct packed {
    logic            ok;
    logic [ValW-1:0] read_value;
    logic [LenW-1:0] length;
    logic            is_empty;
  } list_result_t;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            in_valid_i   = 1'b0;
  logic            in_ready_o;
  logic [CmdW-1:0] command_i    = '0;
  logic [PosW-1:0] position_i   = '0;
  logic [ValW-1:0] item_value_i = '0;
  logic            out_valid_o;
  logic            out_ready_i  = 1'b0;
  logic            ok_o;
  logic [ValW-1:0] read_value_o;
  logic [LenW-1:0] length_o;
  logic            is_empty_o;

  // Shadow copy of the list, front is position 1
  logic [ValW-1:0] shadow_list[$];
  list_result_t    pending_results[$];
  list_result_t    want;
  int unsigned     fail_count      = 0;
  bit              steady_flow     = 1'b0;
  int unsigned     hold_requests   = 0;
  int unsigned     hold_served     = 0;
  int unsigned     hold_left       = 0;

  positional_list_store_unit #(
    .CAPACITY  (ListDepth),
    .DATA_WIDTH(ValW)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .position_i  (position_i),
    .item_value_i(item_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .read_value_o(read_value_o),
    .length_o    (length_o),
    .is_empty_o  (is_empty_o)
  );

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // Apply one command to the shadow list and queue the result it should give
  function automatic void apply_list_cmd(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                                         logic [ValW-1:0] val);
    list_result_t res;
    int unsigned  len;
    len = shadow_list.size();
    res = '0;
    case (cmd)
      CmdInsert: begin
        if (pos >= 1 && pos <= len + 1 && len < ListDepth) begin
          shadow_list.insert(pos - 1, val);
          res.ok = 1'b1;
        end
      end
      CmdRemove: begin
        if (pos >= 1 && pos <= len) begin
          shadow_list.delete(pos - 1);
          res.ok = 1'b1;
        end
      end
      CmdRetrieve: begin
        if (pos >= 1 && pos <= len) begin
          res.read_value = shadow_list[pos - 1];
          res.ok         = 1'b1;
        end
      end
      default: ;
    endcase
    res.length   = LenW'(shadow_list.size());
    res.is_empty = (shadow_list.size() == 0);
    pending_results.push_back(res);
  endfunction

  // Offer one command beat, with an occasional gap first, and hold it until taken
  task automatic send_cmd(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos, logic [ValW-1:0] val);
    while (!steady_flow && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    position_i   <= pos;
    item_value_i <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_list_cmd(cmd, pos, val);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result receiver: random stalls, plus long hold-offs on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = 80;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (!steady_flow && $urandom_range(99) < 6) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: ok=%0b read_value=%0h length=%0d",
               ok_o, read_value_o, length_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, ok_o);
          fail_count++;
        end
        if (read_value_o !== want.read_value) begin
          $error("read_value: expected %0h, got %0h", want.read_value, read_value_o);
          fail_count++;
        end
        if (length_o !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, length_o);
          fail_count++;
        end
        if (is_empty_o !== want.is_empty) begin
          $error("is_empty: expected %0b, got %0b", want.is_empty, is_empty_o);
          fail_count++;
        end
      end
    end
  end

  // Failing commands on an empty list, edge positions, the unused code
  task automatic test_edge_positions();
    send_cmd(CmdRetrieve, 7'd1, '0);
    send_cmd(CmdRemove, 7'd1, '0);
    send_cmd(CmdInsert, 7'd0, 32'hDEAD_BEEF);
    send_cmd(CmdInsert, 7'd2, 32'h1234_5678);
    send_cmd(CmdInsert, 7'd1, 32'hFFFF_FFFF);
    send_cmd(CmdInsert, 7'd1, 32'h0000_0000);
    send_cmd(CmdInsert, 7'd3, 32'hA5A5_A5A5);
    send_cmd(CmdInsert, 7'd2, 32'h5A5A_5A5A);
    send_cmd(CmdRetrieve, 7'd1, 32'hFFFF_FFFF);
    send_cmd(CmdRetrieve, 7'd2, '0);
    send_cmd(CmdRetrieve, 7'd3, '0);
    send_cmd(CmdRetrieve, 7'd4, '0);
    send_cmd(CmdRetrieve, 7'd5, '0);
    send_cmd(CmdRetrieve, 7'd0, '0);
    send_cmd(CmdRetrieve, 7'd127, '0);
    send_cmd(CmdRemove, 7'd0, '0);
    send_cmd(CmdRemove, 7'd127, '0);
    send_cmd(CmdUnused, 7'd1, 32'hFFFF_FFFF);
    send_cmd(CmdUnused, 7'd0, '0);
    send_cmd(CmdRemove, 7'd2, '0);
    send_cmd(CmdRetrieve, 7'd2, '0);
    send_cmd(CmdRemove, 7'd3, '0);
    send_cmd(CmdRemove, 7'd1, '0);
    send_cmd(CmdRemove, 7'd1, '0);
    send_cmd(CmdRetrieve, 7'd1, '0);
  endtask

  // Fill to capacity, then push against the full list
  task automatic test_full_list();
    int unsigned len;
    len = shadow_list.size();
    while (len < ListDepth) begin
      send_cmd(CmdInsert, PosW'($urandom_range(len + 1, 1)), $urandom());
      len = shadow_list.size();
    end
    send_cmd(CmdInsert, PosW'(ListDepth + 1), $urandom());
    send_cmd(CmdInsert, 7'd1, $urandom());
    send_cmd(CmdRetrieve, PosW'(ListDepth), '0);
    send_cmd(CmdRetrieve, PosW'(ListDepth + 1), '0);
    send_cmd(CmdRemove, PosW'(ListDepth), '0);
    send_cmd(CmdInsert, PosW'(ListDepth), $urandom());
    send_cmd(CmdRemove, 7'd1, '0);
  endtask

  // Mostly well-formed commands that sweep the length between empty and full
  task automatic test_random_ops(int unsigned n_items);
    bit              growing;
    int unsigned     len;
    int unsigned     pick;
    logic [CmdW-1:0] cmd;
    logic [PosW-1:0] pos;
    growing = 1'b0;
    for (int unsigned i = 0; i < n_items; i++) begin
      steady_flow = (i >= n_items / 3) && (i < n_items / 3 + 100);
      len = shadow_list.size();
      if (len == ListDepth) growing = 1'b0;
      else if (len == 0) growing = 1'b1;
      else if ($urandom_range(99) < 2) growing = !growing;
      pick = $urandom_range(99);
      if (pick < 8) begin
        // noise: any code, any position
        cmd = CmdW'($urandom_range(3));
        pos = PosW'($urandom_range(127));
      end else begin
        pick = $urandom_range(99);
        if (pick < (growing ? 60 : 15)) cmd = CmdInsert;
        else if (pick < 75) cmd = CmdRemove;
        else cmd = CmdRetrieve;
        if (cmd == CmdInsert) pos = PosW'($urandom_range(len + 1, 1));
        else pos = PosW'($urandom_range((len == 0) ? 1 : len, 1));
      end
      send_cmd(cmd, pos, $urandom());
    end
    steady_flow = 1'b0;
  endtask

  // Hold the result side off for a long stretch while beats keep coming
  task automatic test_output_stall();
    int unsigned len;
    hold_requests++;
    for (int unsigned i = 0; i < 20; i++) begin
      len = shadow_list.size();
      if (i[0]) send_cmd(CmdRetrieve, PosW'($urandom_range((len == 0) ? 1 : len, 1)), '0);
      else send_cmd(CmdInsert, PosW'($urandom_range(len + 1, 1)), $urandom());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_positions();
    test_full_list();
    test_output_stall();
    test_random_ops(360);
    test_output_stall();

    // Let the last beats drain, then settle
    wait_drained();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/plc_pkg.sv
hw/rtl/plc_cell.sv
hw/rtl/positional_list_store_unit.sv
hw/rtl/plc_checker.sv
verif/tb_top.sv
